// ----- rtl/core/dlr_pkg.sv -----
package dlr_pkg;

  // Coordinate and span widths are fixed by the command format
  localparam int unsigned COORD_W = 6;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned COLOR_W = 32;

  localparam int unsigned TILE_SIZE_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // command queue between set-up and stepping
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } front_state_e;

  typedef enum logic {
    BE_IDLE,
    BE_RUN
  } back_state_e;

endpackage

// ----- rtl/core/dlr_front.sv -----
module dlr_front #(
  parameter int unsigned TILE_SIZE = dlr_pkg::TILE_SIZE_DEF,
  parameter int unsigned FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dlr_pkg::COORD_W-1:0] start_x_i,
  input  logic [dlr_pkg::COORD_W-1:0] start_y_i,
  input  logic [dlr_pkg::COORD_W-1:0] stop_x_i,
  input  logic [dlr_pkg::COORD_W-1:0] stop_y_i,
  input  logic [dlr_pkg::COLOR_W-1:0] line_color_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_stall_i,
  output logic [dlr_pkg::COORD_W-1:0] cmd_x0_o,
  output logic [dlr_pkg::COORD_W-1:0] cmd_y0_o,
  output logic [dlr_pkg::CNT_W-1:0]   cmd_n_o,
  output logic                        cmd_y_down_o,
  output logic [FRAC_BITS:0]          cmd_inc_x_o,
  output logic [FRAC_BITS:0]          cmd_inc_y_o,
  output logic [dlr_pkg::COLOR_W-1:0] cmd_color_o
);
  import dlr_pkg::*;

  localparam int unsigned STEP_W = $clog2(FRAC_BITS + 1);
  localparam logic [COORD_W-1:0] CMAX = COORD_W'(TILE_SIZE - 1);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  front_state_e state_q, state_d;

  logic [COORD_W-1:0] cx0, cy0, cx1, cy1, sx0, sy0, sx1, sy1, ax, ay;
  logic               accept, y_down, x_major;
  logic [CNT_W-1:0]   n_comb, m_comb;

  logic [COORD_W-1:0] x0_q, y0_q;
  logic [CNT_W-1:0]   n_q;
  logic               y_down_q, x_major_q;
  logic [COLOR_W-1:0] color_q;
  logic [CNT_W:0]     rem_q, rem_d, trial;
  logic [FRAC_BITS:0] quo_q, quo_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               ge;

  assign accept = in_valid_i && (state_q == FE_IDLE);

  // clamp, order by x, spans
  always_comb begin
    cx0 = (start_x_i > CMAX) ? CMAX : start_x_i;
    cy0 = (start_y_i > CMAX) ? CMAX : start_y_i;
    cx1 = (stop_x_i  > CMAX) ? CMAX : stop_x_i;
    cy1 = (stop_y_i  > CMAX) ? CMAX : stop_y_i;
    if (cx0 > cx1) begin
      sx0 = cx1; sy0 = cy1; sx1 = cx0; sy1 = cy0;
    end else begin
      sx0 = cx0; sy0 = cy0; sx1 = cx1; sy1 = cy1;
    end
    ax      = sx1 - sx0;
    y_down  = sy1 < sy0;
    ay      = y_down ? (sy0 - sy1) : (sy1 - sy0);
    x_major = ax >= ay;
    n_comb  = x_major ? ax : ay;
    m_comb  = x_major ? ay : ax;
  end

  // restoring divide of the minor span by n, one quotient bit a cycle
  always_comb begin
    trial = (step_q == '0) ? rem_q : {rem_q[CNT_W-1:0], 1'b0};
    ge    = trial >= {1'b0, n_q};
    rem_d = rem_q;
    quo_d = quo_q;
    step_d = step_q;
    if (accept) begin
      rem_d  = {1'b0, m_comb};
      step_d = '0;
    end else if (state_q == FE_DIV) begin
      rem_d  = ge ? (trial - {1'b0, n_q}) : trial;
      quo_d  = {quo_q[FRAC_BITS-1:0], ge};
      step_d = step_q + STEP_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: if (in_valid_i && (n_comb != '0)) state_d = FE_DIV;
      FE_DIV:  if (step_q == STEP_W'(FRAC_BITS)) state_d = FE_PUSH;
      FE_PUSH: if (!cmd_stall_i) state_d = FE_IDLE;
      default: state_d = FE_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != FE_IDLE);
    cmd_valid_o = (state_q == FE_PUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    if (accept) begin
      x0_q      <= sx0;
      y0_q      <= sy0;
      n_q       <= n_comb;
      y_down_q  <= y_down;
      x_major_q <= x_major;
      color_q   <= line_color_i;
    end
  end

  assign cmd_x0_o     = x0_q;
  assign cmd_y0_o     = y0_q;
  assign cmd_n_o      = n_q;
  assign cmd_y_down_o = y_down_q;
  assign cmd_inc_x_o  = x_major_q ? ONE : quo_q;
  assign cmd_inc_y_o  = x_major_q ? quo_q : ONE;
  assign cmd_color_o  = color_q;

endmodule

// ----- rtl/core/dlr_queue.sv -----
module dlr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dlr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_stall_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_stall_o = (cnt_q == CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_valid_o && !pop_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      if (push && !pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ----- rtl/core/dlr_back.sv -----
module dlr_back #(
  parameter int unsigned FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_stall_o,
  input  logic [dlr_pkg::COORD_W-1:0] cmd_x0_i,
  input  logic [dlr_pkg::COORD_W-1:0] cmd_y0_i,
  input  logic [dlr_pkg::CNT_W-1:0]   cmd_n_i,
  input  logic                        cmd_y_down_i,
  input  logic [FRAC_BITS:0]          cmd_inc_x_i,
  input  logic [FRAC_BITS:0]          cmd_inc_y_i,
  input  logic [dlr_pkg::COLOR_W-1:0] cmd_color_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dlr_pkg::COORD_W-1:0] pixel_x_o,
  output logic [dlr_pkg::COORD_W-1:0] pixel_y_o,
  output logic [dlr_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                        last_o
);
  import dlr_pkg::*;

  localparam int unsigned POS_W = COORD_W + FRAC_BITS;

  back_state_e state_q, state_d;

  logic [POS_W-1:0]   px_q, py_q, inc_x_ext, inc_y_ext;
  logic [FRAC_BITS:0] inc_x_q, inc_y_q;
  logic               y_down_q;
  logic [CNT_W-1:0]   rem_q;
  logic [COLOR_W-1:0] color_q;
  logic               load, emit, is_last;
  logic               out_valid_q;
  logic [COORD_W-1:0] pix_x_q, pix_y_q;
  logic [COLOR_W-1:0] pix_color_q;
  logic               last_q;

  assign inc_x_ext = POS_W'(inc_x_q);
  assign inc_y_ext = POS_W'(inc_y_q);
  assign is_last   = (rem_q == CNT_W'(1));

  always_comb begin
    load        = (state_q == BE_IDLE) && cmd_valid_i;
    emit        = (state_q == BE_RUN) && (!out_valid_q || !out_stall_i);
    cmd_stall_o = (state_q != BE_IDLE);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_IDLE: if (cmd_valid_i) state_d = BE_RUN;
      BE_RUN:  if (emit && is_last) state_d = BE_IDLE;
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q     <= {cmd_x0_i, {FRAC_BITS{1'b0}}};
      py_q     <= {cmd_y0_i, {FRAC_BITS{1'b0}}};
      inc_x_q  <= cmd_inc_x_i;
      inc_y_q  <= cmd_inc_y_i;
      y_down_q <= cmd_y_down_i;
      rem_q    <= cmd_n_i;
      color_q  <= cmd_color_i;
    end else if (emit) begin
      px_q  <= px_q + inc_x_ext;
      py_q  <= y_down_q ? (py_q - inc_y_ext) : (py_q + inc_y_ext);
      rem_q <= rem_q - CNT_W'(1);
    end
    if (emit) begin
      pix_x_q     <= px_q[POS_W-1:FRAC_BITS];
      pix_y_q     <= py_q[POS_W-1:FRAC_BITS];
      pix_color_q <= color_q;
      last_q      <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign last_o        = last_q;

endmodule

// ----- rtl/core/dda_line_rasterizer_unit.sv -----
// The first pixel of a request follows its divide set-up in the front.
// Throughput: one pixel per cycle within a line while out_stall_i is low; the stepper
//   loads each command from the queue, and the set-up of the next request overlaps drawing.
// Set-up cost comes from the bit-serial restoring divider, one quotient bit a cycle.
// Reset (rst_ni low, asynchronous): both state machines idle, queue empty, no output valid.
module dda_line_rasterizer_unit #(
  parameter int unsigned TILE_SIZE = dlr_pkg::TILE_SIZE_DEF,
  parameter int unsigned FRAC_BITS = dlr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dlr_pkg::COORD_W-1:0] start_x_i,
  input  logic [dlr_pkg::COORD_W-1:0] start_y_i,
  input  logic [dlr_pkg::COORD_W-1:0] stop_x_i,
  input  logic [dlr_pkg::COORD_W-1:0] stop_y_i,
  input  logic [dlr_pkg::COLOR_W-1:0] line_color_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dlr_pkg::COORD_W-1:0] pixel_x_o,
  output logic [dlr_pkg::COORD_W-1:0] pixel_y_o,
  output logic [dlr_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                        last_o
);
  import dlr_pkg::*;

  // queue entry: colour, start point, pixel count, y direction, two increments
  localparam int unsigned INC_W = FRAC_BITS + 1;
  localparam int unsigned Q_W   = COLOR_W + 2 * COORD_W + CNT_W + 1 + 2 * INC_W;

  // front -> queue
  logic               f_valid, f_stall;
  logic [COORD_W-1:0] f_x0, f_y0;
  logic [CNT_W-1:0]   f_n;
  logic               f_y_down;
  logic [INC_W-1:0]   f_inc_x, f_inc_y;
  logic [COLOR_W-1:0] f_color;

  // queue -> back
  logic               b_valid, b_stall;
  logic [COORD_W-1:0] b_x0, b_y0;
  logic [CNT_W-1:0]   b_n;
  logic               b_y_down;
  logic [INC_W-1:0]   b_inc_x, b_inc_y;
  logic [COLOR_W-1:0] b_color;

  logic [Q_W-1:0] q_push_data, q_pop_data;

  // Front: clamps, orders the endpoints by x, finds the major span and divides
  // the minor span by it. Zero-length requests are taken and dropped here.
  dlr_front #(
    .TILE_SIZE (TILE_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .stop_x_i     (stop_x_i),
    .stop_y_i     (stop_y_i),
    .line_color_i (line_color_i),
    .cmd_valid_o  (f_valid),
    .cmd_stall_i  (f_stall),
    .cmd_x0_o     (f_x0),
    .cmd_y0_o     (f_y0),
    .cmd_n_o      (f_n),
    .cmd_y_down_o (f_y_down),
    .cmd_inc_x_o  (f_inc_x),
    .cmd_inc_y_o  (f_inc_y),
    .cmd_color_o  (f_color)
  );

  assign q_push_data = {f_color, f_x0, f_y0, f_n, f_y_down, f_inc_x, f_inc_y};

  // Short queue so the next set-up runs while the stepper draws
  dlr_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_stall_o (f_stall),
    .push_data_i  (q_push_data),
    .pop_valid_o  (b_valid),
    .pop_stall_i  (b_stall),
    .pop_data_o   (q_pop_data)
  );

  assign {b_color, b_x0, b_y0, b_n, b_y_down, b_inc_x, b_inc_y} = q_pop_data;

  // Back: fixed-point stepper, one pixel a cycle while not stalled, into a registered output
  dlr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (b_valid),
    .cmd_stall_o   (b_stall),
    .cmd_x0_i      (b_x0),
    .cmd_y0_i      (b_y0),
    .cmd_n_i       (b_n),
    .cmd_y_down_i  (b_y_down),
    .cmd_inc_x_i   (b_inc_x),
    .cmd_inc_y_i   (b_inc_y),
    .cmd_color_i   (b_color),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o)
  );

endmodule
